// ===== hdl/kda_pkg.sv =====
package kda_pkg;

  localparam int BUTTONS        = 3;
  localparam int ARM_W          = 3;
  localparam int PIN_W          = 8;
  localparam int JOY_PIN_BASE   = 3;
  localparam int FIRST_JOY_CODE = 4;
  localparam int CODE_W         = 4;
  localparam int HOLD_W         = 16;

  typedef logic [CODE_W-1:0] key_code_t;
  typedef logic [HOLD_W-1:0] hold_time_t;

  localparam key_code_t  KEY_NONE   = key_code_t'(0);
  localparam hold_time_t HOLD_RESET = hold_time_t'(10);

  // One scan tick as it travels from the input stage to the key logic.
  typedef struct packed {
    logic [ARM_W-1:0] arm_flags;
    logic [PIN_W-1:0] pin_levels;
  } scan_word_t;

endpackage

// ===== hdl/kda_if.sv =====
interface kda_in_if import kda_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ARM_W-1:0]             arm_flags;
  logic [PIN_W-1:0]             pin_levels;

  modport source (output valid, output arm_flags, output pin_levels, input ready);
  modport sink   (input valid, input arm_flags, input pin_levels, output ready);
endinterface

interface kda_out_if import kda_pkg::*; ();
  logic      valid;
  logic      ready;
  key_code_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

// ===== hdl/kda_in_stage.sv =====
module kda_in_stage import kda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kda_in_if.sink     in_i,
  input  logic       take_i,
  output logic       valid_o,
  output scan_word_t word_o
);

  logic       valid_q, valid_d;
  scan_word_t word_q;
  logic       accept;

  // Refill in the same cycle the held word moves on.
  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.arm_flags  <= in_i.arm_flags;
      word_q.pin_levels <= in_i.pin_levels;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== hdl/kda_key_logic.sv =====
module kda_key_logic import kda_pkg::*; #(
  parameter int JOY_LINES   = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  scan_word_t word_i,
  input  hold_time_t hold_time_i,
  output key_code_t  key_code_o
);

  localparam int CMP_W = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_TWO = COUNT_WIDTH'(2);

  logic [COUNT_WIDTH-1:0] btn_q [BUTTONS];
  logic [COUNT_WIDTH-1:0] btn_d [BUTTONS];
  logic [COUNT_WIDTH-1:0] btn_armed [BUTTONS];
  logic [BUTTONS-1:0]     btn_fire;
  key_code_t              btn_val [BUTTONS];

  logic [COUNT_WIDTH-1:0] joy_q [JOY_LINES];
  logic [COUNT_WIDTH-1:0] joy_d [JOY_LINES];
  logic [JOY_LINES-1:0]   joy_low;
  key_code_t              joy_val [JOY_LINES];
  logic                   any_joy;

  key_code_t last_code_q, last_code_d;

  // Lines past the last pin read as released.
  for (genvar g = 0; g < JOY_LINES; g++) begin : g_joy_pin
    if (JOY_PIN_BASE + g < PIN_W) begin : g_pin
      assign joy_low[g] = ~word_i.pin_levels[JOY_PIN_BASE + g];
    end else begin : g_no_pin
      assign joy_low[g] = 1'b0;
    end
  end

  assign any_joy = |joy_low;

  // Buttons: arm an idle counter, then count while low, clear on release.
  always_comb begin
    for (int i = 0; i < BUTTONS; i++) begin
      btn_armed[i] = (btn_q[i] == '0 && word_i.arm_flags[i]) ? CNT_ONE : btn_q[i];
      btn_fire[i]  = (btn_armed[i] != '0);
      if (btn_fire[i] && !word_i.pin_levels[i]) begin
        btn_d[i]   = (btn_armed[i] == CNT_MAX) ? CNT_MAX : btn_armed[i] + CNT_ONE;
        btn_val[i] = (btn_d[i] == CNT_TWO) ? CODE_W'(i + 1) : KEY_NONE;
      end else begin
        btn_d[i]   = '0;
        btn_val[i] = KEY_NONE;
      end
    end
  end

  // Joystick: report on the second tick, repeat once past the hold time.
  always_comb begin
    for (int i = 0; i < JOY_LINES; i++) begin
      if (joy_low[i]) begin
        joy_d[i] = (joy_q[i] == CNT_MAX) ? CNT_MAX : joy_q[i] + CNT_ONE;
      end else begin
        joy_d[i] = joy_q[i];
      end
      joy_val[i] = (joy_d[i] == CNT_TWO || CMP_W'(joy_d[i]) > CMP_W'(hold_time_i))
                   ? CODE_W'(FIRST_JOY_CODE + i) : KEY_NONE;
    end
  end

  // Later rules override earlier ones; hold the code when none fires.
  always_comb begin
    last_code_d = last_code_q;
    for (int i = 0; i < BUTTONS; i++) begin
      if (btn_fire[i]) begin
        last_code_d = btn_val[i];
      end
    end
    for (int i = 0; i < JOY_LINES; i++) begin
      if (joy_low[i]) begin
        last_code_d = joy_val[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTONS; i++) begin
        btn_q[i] <= '0;
      end
      for (int i = 0; i < JOY_LINES; i++) begin
        joy_q[i] <= '0;
      end
      last_code_q <= KEY_NONE;
    end else if (advance_i) begin
      for (int i = 0; i < BUTTONS; i++) begin
        btn_q[i] <= btn_d[i];
      end
      for (int i = 0; i < JOY_LINES; i++) begin
        joy_q[i] <= any_joy ? joy_d[i] : '0;
      end
      last_code_q <= last_code_d;
    end
  end

  assign key_code_o = last_code_q;

`ifndef SYNTHESIS
  for (genvar g = 0; g < BUTTONS; g++) begin : g_btn_chk
    a_btn_never_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
      btn_q[g] != CNT_ONE)
      else $error("button counter left armed but not counted");
  end

  a_joy_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !any_joy |=> joy_q[0] == '0)
    else $error("joystick counters not cleared on idle tick");

  a_code_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(last_code_q))
    else $error("key code changed without a tick");
`endif

endmodule

// ===== hdl/key_debounce_autorepeat_top.sv =====
// Key debounce with joystick auto-repeat.
//
// in_i carries one scan tick per word: arm_flags (press edges seen per button)
// and pin_levels (active-low buttons on bits 0-2, joystick select, down, left,
// right, up on bits 3-7). out_o returns exactly one word per tick: key_code,
// 0 for none, 1-3 for the buttons, 4-8 for the joystick lines, or the last
// code when no rule fires.
//
// Pipeline: the word waits in the input register; as it advances, the counter
// update loads the code register and sets out_o.valid, and the word cannot
// advance while the code register holds a result that is not yet taken.
// Throughput, without stalls, is one word per cycle; all counters update in
// parallel in the key logic, and the input register refills in the cycle its
// word moves on. When out_o stalls, the code register holds, the input register
// takes one more word and then in_i.ready drops until the result is taken.
//
// Reset clears all counters and the code to none and sets hold_time to 10.
// Write hold_time through cfg_we_i/cfg_wdata_i only while the block is idle.
module key_debounce_autorepeat_top import kda_pkg::*; #(
  parameter int JOY_LINES   = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  hold_time_t cfg_wdata_i,
  kda_in_if.sink     in_i,
  kda_out_if.source  out_o
);

  hold_time_t hold_q;
  logic       s1_valid;
  scan_word_t s1_word;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       advance;

  // Hold register; load it on the write strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  // Advance a tick when the code register is empty or being drained.
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = s1_valid && out_free;

  kda_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (advance),
    .valid_o (s1_valid),
    .word_o  (s1_word)
  );

  kda_key_logic #(
    .JOY_LINES   (JOY_LINES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_key_logic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .word_i      (s1_word),
    .hold_time_i (hold_q),
    .key_code_o  (out_o.key_code)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_valid)
    else $error("accepted word lost in input stage");

  a_out_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid))
    else $error("result shown without a pending tick");
`endif

endmodule

// ===== test/key_debounce_autorepeat_top_tb.sv =====
module key_debounce_autorepeat_top_tb;
  import kda_pkg::*;

  localparam int JOY_LINES   = 5;
  localparam int COUNT_WIDTH = 16;
  localparam int JOY_W       = PIN_W - JOY_PIN_BASE;
  // Cycles without any accepted word before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off plus random idle
  // cycles, so this limit leaves a wide margin.
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int LONG_HOLD      = 20;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  hold_time_t cfg_wdata;

  kda_in_if  in_if ();
  kda_out_if out_if ();

  key_debounce_autorepeat_top #(
    .JOY_LINES   (JOY_LINES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // 4-unit clock: two units high, two units low.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the key logic's counters, the
  // last reported code and the hold_time register.
  // ---------------------------------------------------------------------
  hold_time_t hold_q;
  count_t     btn_cnt [BUTTONS];
  count_t     joy_cnt [JOY_LINES];
  key_code_t  last_key;

  key_code_t  expected_keys [$];   // predicted codes, oldest first
  key_code_t  want_key;
  int         err_count    = 0;
  int         keys_seen    = 0;
  int         stuck_cycles = 0;

  // Idle rates in percent, changed between phases by the sequence below.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Receiver hold-off: the sequence posts a request, the receiver process
  // counts it down in cycles on its own.
  int rx_hold_req  = 0;
  int rx_hold_left = 0;

  // Advance the predicted key logic by one scan tick and return the code
  // it reports. Rules run in a fixed order; the last one that fires wins,
  // and a tick on which none fires keeps the previous code.
  function automatic key_code_t predict_key(input logic [ARM_W-1:0] arm,
                                            input logic [PIN_W-1:0] pins);
    logic any_joy;
    any_joy = 1'b0;
    for (int b = 0; b < BUTTONS; b++) begin
      // Arm only an idle counter; a flag while counting is ignored.
      if (btn_cnt[b] == '0 && arm[b]) btn_cnt[b] = count_t'(1);
      if (btn_cnt[b] != '0) begin
        if (!pins[b]) begin
          if (btn_cnt[b] != COUNT_MAX) btn_cnt[b] = btn_cnt[b] + count_t'(1);
          last_key = (btn_cnt[b] == count_t'(2)) ? key_code_t'(b + 1) : KEY_NONE;
        end else begin
          btn_cnt[b] = '0;
          last_key   = KEY_NONE;
        end
      end
    end
    for (int j = 0; j < JOY_LINES; j++) begin
      // Lines past the last pin read as released.
      if (JOY_PIN_BASE + j < PIN_W && !pins[JOY_PIN_BASE + j]) begin
        any_joy = 1'b1;
        if (joy_cnt[j] != COUNT_MAX) joy_cnt[j] = joy_cnt[j] + count_t'(1);
        if (joy_cnt[j] == count_t'(2) || joy_cnt[j] > hold_q)
          last_key = key_code_t'(FIRST_JOY_CODE + j);
        else
          last_key = KEY_NONE;
      end
    end
    // Joystick counters clear only when every line is released.
    if (!any_joy) begin
      for (int j = 0; j < JOY_LINES; j++) joy_cnt[j] = '0;
    end
    return last_key;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at output word %0d: %s got %0d, want %0d",
             keys_seen, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Sender: offer one scan word, idling at random first, and predict its
  // code once the word is accepted. Valid is left high after the accept
  // so back-to-back words keep it asserted without a drop.
  // ---------------------------------------------------------------------
  task automatic send_scan(input logic [ARM_W-1:0] arm, input logic [PIN_W-1:0] pins);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.arm_flags  <= arm;
    in_if.pin_levels <= pins;
    do @(posedge clk_i); while (!in_if.ready);
    expected_keys.push_back(predict_key(arm, pins));
  endtask

  // Drop valid and wait until every predicted code has come back, then
  // let the pipeline settle.
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write hold_time while the block is idle and mirror it in the predictor.
  task automatic write_hold(input hold_time_t value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    hold_q     = value;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Button arming, counting, release and rule order.
  task automatic test_button_rules();
    send_scan(3'b000, 8'hFE);   // idle button held low without arm: nothing
    send_scan(3'b001, 8'hFE);   // arm and hold: button 0 reports
    send_scan(3'b001, 8'hFE);   // arm while counting is ignored
    send_scan(3'b000, 8'hFF);   // release clears the code
    send_scan(3'b010, 8'hFF);   // armed but not held: clears at once
    send_scan(3'b110, 8'hF9);   // buttons 1 and 2 together: the later wins
    send_scan(3'b000, 8'hFB);   // button 1 released while 2 keeps counting
    send_scan(3'b000, 8'hFF);
    send_scan(3'b111, 8'h00);   // every line low at once
    send_scan(3'b000, 8'h00);
    send_scan(3'b000, 8'hFF);
  endtask

  // Joystick second-tick report, line change while held, code hold.
  task automatic test_joystick_rules();
    repeat (3) send_scan(3'b000, 8'hF7);   // select held
    send_scan(3'b000, 8'h77);              // up joins while select is held
    send_scan(3'b000, 8'h7F);              // up alone keeps counting
    send_scan(3'b000, 8'hFF);              // no rule fires: code is held
  endtask

  // hold_time at and below its lower limit: 0 repeats from the start.
  task automatic test_hold_extremes();
    for (int k = 0; k < 3; k++) begin
      write_hold(hold_time_t'(k));
      repeat (3) send_scan(3'b000, 8'hDF);   // left held
      send_scan(3'b000, 8'hFF);
    end
  endtask

  // Mostly well-formed press/hold/release gestures with random content,
  // plus stretches of raw noise.
  task automatic test_random_scans(input int n_items);
    int                 done_items;
    int                 kind;
    int                 len;
    logic [ARM_W-1:0]   buttons;
    logic [JOY_W-1:0]   joy;
    logic [PIN_W-1:0]   pins;
    logic [ARM_W-1:0]   arm;
    done_items = 0;
    while (done_items < n_items) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, hold_q + 6);
      if (kind < 4) begin
        // Press one or more buttons, arm on the first tick, hold, release.
        buttons = ARM_W'($urandom_range(1, 7));
        for (int t = 0; t < len; t++) begin
          pins = {{(PIN_W-BUTTONS){1'b1}}, ~buttons};
          if ($urandom_range(0, 9) == 0) pins[BUTTONS-1:0] = BUTTONS'($urandom);
          arm = (t == 0) ? buttons : '0;
          if ($urandom_range(0, 7) == 0) arm = ARM_W'($urandom);
          send_scan(arm, pins);
        end
        send_scan('0, '1);
        done_items += len + 1;
      end else if (kind < 8) begin
        // Hold one joystick line, sometimes several, at times long enough to repeat.
        joy = JOY_W'(1 << $urandom_range(0, JOY_W - 1));
        if ($urandom_range(0, 3) == 0) joy |= JOY_W'($urandom);
        for (int t = 0; t < len; t++) begin
          if ($urandom_range(0, 11) == 0) joy = JOY_W'(1 << $urandom_range(0, JOY_W - 1));
          pins = {~joy, {JOY_PIN_BASE{1'b1}}};
          arm  = ($urandom_range(0, 9) == 0) ? ARM_W'($urandom) : '0;
          send_scan(arm, pins);
        end
        send_scan('0, '1);
        done_items += len + 1;
      end else begin
        for (int t = 0; t < len; t++) send_scan(ARM_W'($urandom), PIN_W'($urandom));
        done_items += len;
      end
    end
  endtask

  // Stall the receiver for a long stretch while words keep coming, so the
  // block fills and drops in_i.ready; wait until all is back, then send more.
  task automatic test_backpressure();
    write_hold(hold_time_t'($urandom_range(2, 14)));
    rx_hold_req = HOLDOFF_CYCLES;
    test_random_scans(60);
    wait_quiet();
    test_random_scans(60);
  endtask

  // hold_time one below its upper limit: a long button hold reports only on
  // its first tick, and a long joystick hold reports once and does not repeat.
  task automatic test_long_holds();
    write_hold(hold_time_t'(65534));
    send_scan(3'b001, 8'hFE);
    repeat (LONG_HOLD) send_scan(3'b000, 8'hFE);
    send_scan(3'b000, 8'hFF);
    repeat (LONG_HOLD) send_scan(3'b000, 8'h7F);
    send_scan(3'b000, 8'hFF);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: drive ready, honoring a posted hold-off first.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      out_if.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Checker: compare every accepted output word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_keys.size() == 0) begin
        report_mismatch("unexpected word, key_code", out_if.key_code, -1);
      end else begin
        want_key = expected_keys.pop_front();
        if (out_if.key_code !== want_key)
          report_mismatch("key_code", out_if.key_code, want_key);
      end
      keys_seen++;
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero.
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.arm_flags  <= '0;
    in_if.pin_levels <= '1;

    hold_q   = HOLD_RESET;
    last_key = KEY_NONE;
    for (int b = 0; b < BUTTONS; b++) btn_cnt[b] = '0;
    for (int j = 0; j < JOY_LINES; j++) joy_cnt[j] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: sender idles lightly, receiver stalls often.
    tx_idle_pct = 35;
    rx_idle_pct = 62;
    test_button_rules();
    test_joystick_rules();
    test_hold_extremes();
    write_hold(hold_time_t'($urandom_range(2, 14)));
    test_random_scans(350);

    // Phase 2: swap the two rates.
    tx_idle_pct = 62;
    rx_idle_pct = 35;
    test_backpressure();
    write_hold(hold_time_t'($urandom_range(2, 14)));
    test_random_scans(300);

    // Phase 3: full rate on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_long_holds();
    write_hold(hold_time_t'($urandom_range(2, 14)));
    test_random_scans(400);

    // Drain, let the pipeline settle, then report.
    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && expected_keys.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/kda_pkg.sv
hdl/kda_if.sv
hdl/kda_in_stage.sv
hdl/kda_key_logic.sv
hdl/key_debounce_autorepeat_top.sv
test/key_debounce_autorepeat_top_tb.sv
